[rtl/esed_pkg.sv]
// Shared constants, request codes and inter-module structs for the energy
// speech endpoint detector. No dependencies; every other file imports this.
package esed_pkg;

    localparam int unsigned FRAME_SAMPLES = 512;
    localparam int unsigned RING_DEPTH    = 4 * FRAME_SAMPLES;
    localparam int unsigned RING_AW       = $clog2(RING_DEPTH);
    localparam int unsigned FRAME_AW      = $clog2(FRAME_SAMPLES);
    localparam int unsigned QSTEP_W       = FRAME_AW + 3;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned QSUM_W   = 23;
    localparam int unsigned NOISE_W  = 28;
    localparam int unsigned SENS_W   = 8;
    localparam int unsigned CAL_W    = 4;
    localparam int unsigned LOW_W    = 2;
    localparam int unsigned PHASE_W  = 2;

    localparam int unsigned THRESH_DIV = 40;
    localparam int unsigned END_FACTOR = 3;
    localparam int unsigned LHS_W      = QSUM_W + 6;
    localparam int unsigned START_W    = NOISE_W + SENS_W;
    localparam int unsigned END_W      = NOISE_W + 2;

    localparam logic [CAL_W-1:0]   CAL_FRAMES   = CAL_W'(10);
    localparam logic [LOW_W-1:0]   LOW_LAST     = LOW_W'(2);
    localparam logic [SENS_W-1:0]  SENS_RESET   = SENS_W'(4);
    localparam logic [PHASE_W-1:0] PHASE_NONE   = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PHASE_ONE    = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PHASE_TWO    = PHASE_W'(2);

    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);

    typedef enum logic [1:0] {
        REQ_AUDIO = 2'd0,
        REQ_REARM = 2'd1,
        REQ_RECAL = 2'd2
    } t_req;

    // Ring access issued by the front for one accepted item
    typedef struct packed {
        logic                wr_en;
        logic [RING_AW-1:0]  wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [RING_AW-1:0]  rd_addr;
        logic                rd_last;
    } t_ring_cmd;

    // One result item on its way to the output
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_emit;

endpackage

[rtl/esed_front.sv]
// Front end: accepts items, tracks frame/quarter position, energy sums,
// calibration and the speech start/end decisions. Issues ring accesses.
// Depends on esed_pkg.
module esed_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [esed_pkg::SENS_W-1:0]    i_cfg_wdata,
    input  logic                           i_accept,
    input  logic [1:0]                     i_req,
    input  logic [esed_pkg::SAMPLE_W-1:0]  i_sample,
    output esed_pkg::t_ring_cmd            o_cmd
);
    import esed_pkg::*;

    localparam logic [FRAME_AW-1:0] FRAME_LAST = FRAME_AW'(FRAME_SAMPLES - 1);
    localparam logic [RING_AW-1:0]  RING_LAST  = RING_AW'(RING_DEPTH - 1);

    logic [RING_AW-1:0]  r_ring_pos, n_ring_pos;
    logic [FRAME_AW-1:0] r_frame_pos, n_frame_pos;
    logic [FRAME_AW-1:0] r_qrem, n_qrem;
    logic [QSUM_W-1:0]   r_qsum, n_qsum;
    logic                r_above, n_above;
    logic                r_below, n_below;
    logic [NOISE_W-1:0]  r_noise, n_noise;
    logic [CAL_W-1:0]    r_cal_cnt, n_cal_cnt;
    logic                r_started, n_started;
    logic                r_ended, n_ended;
    logic [LOW_W-1:0]    r_low_cnt, n_low_cnt;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [SENS_W-1:0]   r_sens;

    logic [START_W-1:0]  start_rhs;
    logic [END_W-1:0]    end_rhs;
    logic                frame_end;
    logic                cal_done;
    logic [SAMPLE_W-1:0] mag;
    logic [QSUM_W:0]     qsum_add;
    logic [QSUM_W-1:0]   qsum_sat;
    logic [NOISE_W:0]    noise_add;
    logic [NOISE_W-1:0]  noise_sat;
    logic [LHS_W-1:0]    lhs;
    logic                lhs_above;
    logic                lhs_below;
    logic [QSTEP_W-1:0]  qstep;
    logic                qbound;
    logic                above_q;
    logic                below_q;
    logic                started_q;
    logic                adv;
    logic [RING_AW:0]    rd_sum;
    t_ring_cmd           cmd;

    assign frame_end = (r_frame_pos == FRAME_LAST);
    assign cal_done  = (r_cal_cnt >= CAL_FRAMES);

    assign mag       = i_sample[SAMPLE_W-1] ? (~i_sample + SAMPLE_W'(1)) : i_sample;
    assign qsum_add  = {1'b0, r_qsum} + (QSUM_W + 1)'(mag);
    assign qsum_sat  = qsum_add[QSUM_W] ? {QSUM_W{1'b1}} : qsum_add[QSUM_W-1:0];
    assign noise_add = {1'b0, r_noise} + (NOISE_W + 1)'(mag);
    assign noise_sat = noise_add[NOISE_W] ? {NOISE_W{1'b1}} : noise_add[NOISE_W-1:0];

    // Cross-multiplied thresholds, compared exactly against the current registers
    assign start_rhs = START_W'(r_noise) * START_W'(r_sens);
    assign end_rhs   = END_W'(r_noise) * END_W'(END_FACTOR);
    assign lhs       = LHS_W'(qsum_sat) * LHS_W'(THRESH_DIV);
    assign lhs_above = (START_W'(lhs) > start_rhs);
    assign lhs_below = (END_W'(lhs) < end_rhs);

    // Quarter boundary: floor(4*pos/N) steps when the remainder of 4*pos wraps
    assign qstep  = QSTEP_W'(r_qrem) + QSTEP_W'(4);
    assign qbound = frame_end || (qstep >= QSTEP_W'(FRAME_SAMPLES));

    // Play out the slot three frames behind the write pointer
    assign rd_sum = (RING_AW + 1)'(r_ring_pos) + (RING_AW + 1)'(FRAME_SAMPLES);

    always_comb begin
        n_ring_pos  = r_ring_pos;
        n_frame_pos = r_frame_pos;
        n_qrem      = r_qrem;
        n_qsum      = r_qsum;
        n_above     = r_above;
        n_below     = r_below;
        n_noise     = r_noise;
        n_cal_cnt   = r_cal_cnt;
        n_started   = r_started;
        n_ended     = r_ended;
        n_low_cnt   = r_low_cnt;
        n_phase     = r_phase;
        above_q     = r_above;
        below_q     = r_below;
        started_q   = r_started;
        adv         = 1'b0;

        cmd.wr_en   = 1'b0;
        cmd.wr_addr = r_ring_pos;
        cmd.wr_data = i_sample;
        cmd.rd_en   = 1'b0;
        cmd.rd_addr = (rd_sum >= (RING_AW + 1)'(RING_DEPTH))
                      ? RING_AW'(rd_sum - (RING_AW + 1)'(RING_DEPTH))
                      : rd_sum[RING_AW-1:0];
        cmd.rd_last = 1'b0;

        if (i_accept) begin
            unique case (i_req)
                REQ_REARM: begin
                    n_started = 1'b0;
                    n_ended   = 1'b0;
                    n_low_cnt = '0;
                    n_phase   = PHASE_NONE;
                end
                REQ_RECAL: begin
                    n_started = 1'b0;
                    n_ended   = 1'b0;
                    n_low_cnt = '0;
                    n_phase   = PHASE_NONE;
                    n_noise   = '0;
                    n_cal_cnt = '0;
                end
                REQ_AUDIO: begin
                    if (r_ended) begin
                        // Drain the pending frames, ignore the sample
                        if (r_phase != PHASE_NONE) begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_last = (r_phase == PHASE_ONE) && frame_end;
                            adv         = 1'b1;
                            if (frame_end) begin
                                n_phase = r_phase - PHASE_W'(1);
                            end
                        end
                    end else begin
                        cmd.rd_en = (r_phase != PHASE_NONE);
                        cmd.wr_en = 1'b1;
                        adv       = 1'b1;
                        if (!cal_done) begin
                            n_noise = noise_sat;
                        end
                        if (qbound) begin
                            if (cal_done) begin
                                above_q = r_above && lhs_above;
                                below_q = r_below && lhs_below;
                            end
                            n_qsum = '0;
                        end else begin
                            n_qsum = qsum_sat;
                        end
                        n_above = above_q;
                        n_below = below_q;
                        if (frame_end) begin
                            if (!cal_done) begin
                                n_cal_cnt = r_cal_cnt + CAL_W'(1);
                            end else begin
                                started_q = r_started || above_q;
                                n_started = started_q;
                                if (started_q) begin
                                    n_phase = PHASE_ONE;
                                    if (below_q) begin
                                        if (r_low_cnt == LOW_LAST) begin
                                            n_ended   = 1'b1;
                                            n_low_cnt = '0;
                                            n_phase   = PHASE_TWO;
                                        end else begin
                                            n_low_cnt = r_low_cnt + LOW_W'(1);
                                        end
                                    end
                                end else begin
                                    n_phase = PHASE_NONE;
                                end
                            end
                            n_above = 1'b1;
                            n_below = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (adv) begin
            n_ring_pos  = (r_ring_pos == RING_LAST) ? '0 : r_ring_pos + RING_AW'(1);
            n_frame_pos = frame_end ? '0 : r_frame_pos + FRAME_AW'(1);
            n_qrem      = (qstep >= QSTEP_W'(FRAME_SAMPLES))
                          ? FRAME_AW'(qstep - QSTEP_W'(FRAME_SAMPLES))
                          : FRAME_AW'(qstep);
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_pos  <= '0;
            r_frame_pos <= '0;
            r_qrem      <= '0;
            r_qsum      <= '0;
            r_above     <= 1'b1;
            r_below     <= 1'b1;
            r_noise     <= '0;
            r_cal_cnt   <= '0;
            r_started   <= 1'b0;
            r_ended     <= 1'b0;
            r_low_cnt   <= '0;
            r_phase     <= PHASE_NONE;
            r_sens      <= SENS_RESET;
        end else begin
            r_ring_pos  <= n_ring_pos;
            r_frame_pos <= n_frame_pos;
            r_qrem      <= n_qrem;
            r_qsum      <= n_qsum;
            r_above     <= n_above;
            r_below     <= n_below;
            r_noise     <= n_noise;
            r_cal_cnt   <= n_cal_cnt;
            r_started   <= n_started;
            r_ended     <= n_ended;
            r_low_cnt   <= n_low_cnt;
            r_phase     <= n_phase;
            if (i_cfg_we) begin
                r_sens <= i_cfg_wdata;
            end
        end
    end

endmodule

[rtl/esed_ring.sv]
// Four-frame sample ring: one write and one registered read per cycle.
// Read and write addresses of one item are always a frame apart. Depends on esed_pkg.
module esed_ring (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  esed_pkg::t_ring_cmd  i_cmd,
    output logic                 o_vld,
    output esed_pkg::t_emit      o_item
);
    import esed_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_last;
    logic                r_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
            r_last    <= i_cmd.rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_cmd.rd_en;
        end
    end

    assign o_vld         = r_vld;
    assign o_item.sample = r_rd_data;
    assign o_item.last   = r_last;

endmodule

[rtl/esed_outq.sv]
// Output queue: small register FIFO that decouples the ring read stage from
// the master stream and grants input credit. Depends on esed_pkg.
module esed_outq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  esed_pkg::t_emit                i_item,
    output logic                           o_credit,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [esed_pkg::SAMPLE_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast
);
    import esed_pkg::*;

    localparam logic [OUTQ_AW-1:0] PTR_LAST = OUTQ_AW'(OUTQ_DEPTH - 1);

    t_emit              r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [OUTQ_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [OUTQ_AW:0]   r_count, n_count;
    logic               pop;

    assign m_axis_tvalid = (r_count != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_mem[r_rd_ptr].sample;
    assign m_axis_tlast  = r_mem[r_rd_ptr].last;

    // Leave room for the item already in the read stage
    assign o_credit = ((r_count + (OUTQ_AW + 1)'(i_push)) < (OUTQ_AW + 1)'(OUTQ_DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + OUTQ_AW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + OUTQ_AW'(1);
        end
        if (i_push && !pop) begin
            n_count = r_count + (OUTQ_AW + 1)'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - (OUTQ_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/energy_speech_endpoint_detector.sv]
// Top level of the energy speech endpoint detector: front end, sample ring
// and output queue. Depends on esed_pkg, esed_front, esed_ring, esed_outq.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: request kind, tdata: sample
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: sample, tlast: end of utterance
//  cfg       in   i_cfg_we                       i_cfg_wdata: start sensitivity
//
// One item per cycle while s_axis_tready is high; a result passes the ring read register,
// then the output queue, before it shows on m_axis.
// s_axis_tready is low in reset and whenever the 4-entry output queue could not
// hold the ring read stage plus one more.
// Reset is synchronous, active low; no clearing pass, ring contents stay as they were.
module energy_speech_endpoint_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // [7:0] start_sensitivity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] sample
    input  logic [1:0]  s_axis_tuser,    // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [15:0] out_sample
    output logic        m_axis_tlast     // out_last
);
    import esed_pkg::*;

    t_ring_cmd cmd;
    t_emit     ring_item;
    logic      ring_vld;
    logic      credit;
    logic      accept;

    // Hold off input while in reset
    assign s_axis_tready = credit && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;

    esed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_req       (s_axis_tuser),
        .i_sample    (s_axis_tdata),
        .o_cmd       (cmd)
    );

    esed_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_vld   (ring_vld),
        .o_item  (ring_item)
    );

    esed_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (ring_vld),
        .i_item        (ring_item),
        .o_credit      (credit),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[tb/energy_speech_endpoint_detector_test.sv]
// Self-checking bench for energy_speech_endpoint_detector: calibration, speech start and end,
// rearm and recalibration, playback drain, with random idling on both streams.
// Depends on esed_pkg and the RTL top level only.
`timescale 1ns / 100ps

import esed_pkg::*;

// Tracks the detector state and holds the playback samples still owed by the block
class speech_tracker;
    localparam int unsigned PART_TOP             = (1 << QSUM_W) - 1;
    localparam int unsigned NOISE_TOP            = (1 << NOISE_W) - 1;
    localparam int unsigned QUIET_FRAMES_TO_END  = 3;

    logic [SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned slot           = 0;
    int unsigned part_sum       = 0;
    bit          quarters_loud  = 1'b1;
    bit          quarters_quiet = 1'b1;
    int unsigned noise_sum      = 0;
    int unsigned cal_count      = 0;
    bit          talking        = 1'b0;
    bit          finished       = 1'b0;
    int unsigned quiet_run      = 0;
    int unsigned frames_to_play = 0;
    logic [SENS_W-1:0] sens     = SENS_RESET;

    t_emit       expected_playback [$];
    int unsigned errors         = 0;
    int unsigned results_seen   = 0;

    function void set_sensitivity(logic [SENS_W-1:0] v);
        sens = v;
    endfunction

    function int unsigned frame_pos();
        return slot % FRAME_SAMPLES;
    endfunction

    function int unsigned pending();
        return expected_playback.size();
    endfunction

    function bit draining();
        return finished && frames_to_play != 0;
    endfunction

    // Queue the sample that lies three frames back from the write slot
    function void play_back(bit last);
        t_emit e;
        e.sample = ring[(slot + FRAME_SAMPLES) % RING_DEPTH];
        e.last   = last;
        expected_playback = {expected_playback, e};
    endfunction

    function void take_request(logic [1:0] kind, logic [15:0] raw);
        int unsigned pos, mag, qcur, qnext, acc;
        bit frame_end;
        longint unsigned scaled, start_lim, end_lim;
        pos       = slot % FRAME_SAMPLES;
        frame_end = (pos == FRAME_SAMPLES - 1);
        if (kind == REQ_REARM || kind == REQ_RECAL) begin
            talking        = 1'b0;
            finished       = 1'b0;
            quiet_run      = 0;
            frames_to_play = 0;
            if (kind == REQ_RECAL) begin
                noise_sum = 0;
                cal_count = 0;
            end
            return;
        end
        if (kind != REQ_AUDIO)
            return;

        // After the end: play out what is left, drop the incoming sample
        if (finished) begin
            if (frames_to_play == 0)
                return;
            play_back(frames_to_play == 1 && frame_end);
            slot = (slot + 1) % RING_DEPTH;
            if (frame_end)
                frames_to_play--;
            return;
        end

        if (frames_to_play != 0)
            play_back(1'b0);
        ring[slot] = raw;
        mag   = raw[15] ? 32'h10000 - raw : raw;
        qcur  = pos * 4 / FRAME_SAMPLES;
        qnext = (pos + 1) * 4 / FRAME_SAMPLES;

        if (cal_count < CAL_FRAMES) begin
            acc       = noise_sum + mag;
            noise_sum = (acc > NOISE_TOP) ? NOISE_TOP : acc;
        end
        acc      = part_sum + mag;
        part_sum = (acc > PART_TOP) ? PART_TOP : acc;

        if (frame_end || qnext != qcur) begin
            if (cal_count >= CAL_FRAMES) begin
                scaled    = part_sum;
                scaled    = scaled * THRESH_DIV;
                start_lim = noise_sum;
                start_lim = start_lim * sens;
                end_lim   = noise_sum;
                end_lim   = end_lim * END_FACTOR;
                if (!(scaled > start_lim))
                    quarters_loud = 1'b0;
                if (!(scaled < end_lim))
                    quarters_quiet = 1'b0;
            end
            part_sum = 0;
        end

        if (frame_end) begin
            if (cal_count < CAL_FRAMES) begin
                cal_count++;
            end else begin
                if (quarters_loud)
                    talking = 1'b1;
                if (talking) begin
                    frames_to_play = 1;
                    // loud frames do not clear the quiet count
                    if (quarters_quiet) begin
                        quiet_run++;
                        if (quiet_run >= QUIET_FRAMES_TO_END) begin
                            finished       = 1'b1;
                            quiet_run      = 0;
                            frames_to_play = 2;
                        end
                    end
                end else begin
                    frames_to_play = 0;
                end
            end
            quarters_loud  = 1'b1;
            quarters_quiet = 1'b1;
        end
        slot = (slot + 1) % RING_DEPTH;
    endfunction

    function void check_playback(logic [15:0] smp, logic last);
        t_emit want;
        results_seen++;
        if (expected_playback.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("output item %0d not expected: sample %h last %b",
                         results_seen, smp, last);
            return;
        end
        want = expected_playback.pop_front();
        if (want.sample !== smp || want.last !== last) begin
            errors++;
            if (errors <= 10)
                $display("output item %0d: expected sample %h last %b, got sample %h last %b",
                         results_seen, want.sample, want.last, smp, last);
        end
    endfunction
endclass

module energy_speech_endpoint_detector_test;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum {LVL_QUIET, LVL_LOUD, LVL_MIXED, LVL_WILD} t_level;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;    // [15:0] sample
    logic [1:0]  s_axis_tuser  = 2'd0;     // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [15:0] out_sample
    logic        m_axis_tlast;

    speech_tracker tracker;

    energy_speech_endpoint_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_playback(m_axis_tdata, m_axis_tlast);
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(50, 10);
    endfunction

    function automatic logic [15:0] make_sample(t_level lvl, int unsigned amp);
        logic [15:0] mag;
        case (lvl)
            LVL_QUIET: begin
                mag = 16'($urandom_range(amp, 0));
            end
            LVL_LOUD: begin
                if ($urandom_range(31, 0) == 0)
                    return $urandom_range(1, 0) ? 16'h8000 : 16'h7FFF;
                mag = 16'($urandom_range(32767, 8000));
            end
            default: begin
                return 16'($urandom);
            end
        endcase
        return $urandom_range(1, 0) ? -mag : mag;
    endfunction

    task automatic send_item(logic [1:0] kind, logic [15:0] smp, bit burst);
        int unsigned gap;
        gap = burst ? 0 : idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_request(kind, smp);
    endtask

    // Finish the current frame with the given loudness per quarter
    task automatic send_frame(t_level lvl, int unsigned amp, bit cut);
        t_level quarter_lvl [4];
        int unsigned left, cut_at, k;
        bit burst;
        foreach (quarter_lvl[q]) begin
            if (lvl != LVL_MIXED)
                quarter_lvl[q] = lvl;
            else if ($urandom_range(1, 0) == 1)
                quarter_lvl[q] = LVL_LOUD;
            else
                quarter_lvl[q] = LVL_QUIET;
        end
        burst  = ($urandom_range(3, 0) == 0);
        left   = FRAME_SAMPLES - tracker.frame_pos();
        cut_at = cut ? $urandom_range(left - 1, 0) : left;
        for (k = 0; k < left; k++) begin
            if (k == cut_at)
                send_item(REQ_REARM, 16'($urandom), burst);
            if ($urandom_range(255, 0) == 0)
                send_item(REQ_UNUSED, 16'($urandom), burst);
            send_item(REQ_AUDIO,
                      make_sample(quarter_lvl[tracker.frame_pos() * 4 / FRAME_SAMPLES], amp),
                      burst);
        end
    endtask

    // Write only with the block idle: drain results, then allow for its latency
    task automatic write_sensitivity(logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_sensitivity(v);
    endtask

    task automatic run_utterance(logic [7:0] sens, bit write_cfg, bit recal,
                                 int unsigned amp, bit cut);
        int unsigned f, k, cut_at;
        if (write_cfg)
            write_sensitivity(sens);
        send_item(recal ? REQ_RECAL : REQ_REARM, 16'($urandom), 1'b0);
        // the frame in progress counts as the first calibration frame
        if (recal)
            repeat (CAL_FRAMES) send_frame(LVL_QUIET, amp, 1'b0);
        send_frame($urandom_range(1, 0) ? LVL_QUIET : LVL_MIXED, amp, 1'b0);
        send_frame(LVL_LOUD, amp, 1'b0);
        repeat ($urandom_range(4, 1))
            send_frame(t_level'($urandom_range(3, 0)), amp, cut && $urandom_range(3, 0) == 0);
        // quiet, loud, then quiet until the end: the quiet count must survive the loud frame
        f = 0;
        while (tracker.talking && !tracker.finished && f < 6) begin
            send_frame(f == 1 ? LVL_LOUD : LVL_QUIET, amp, 1'b0);
            f++;
        end
        k      = 1;
        cut_at = cut ? $urandom_range(1000, 1) : 0;
        while (tracker.draining()) begin
            if (k == cut_at)
                send_item(REQ_REARM, 16'($urandom), 1'b0);
            else
                send_item(REQ_AUDIO, 16'($urandom), 1'b0);
            k++;
        end
        repeat ($urandom_range(5, 1)) send_item(REQ_AUDIO, 16'($urandom), 1'b0);
    endtask

    initial begin : stimulus
        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(REQ_UNUSED, 16'hFFFF, 1'b0);
        send_item(REQ_REARM,  16'h1234, 1'b0);
        send_item(REQ_AUDIO,  16'h8000, 1'b0);
        send_item(REQ_AUDIO,  16'h7FFF, 1'b0);
        send_item(REQ_AUDIO,  16'h0000, 1'b0);
        send_item(REQ_AUDIO,  16'hFFFF, 1'b0);
        send_item(REQ_AUDIO,  16'h0001, 1'b1);
        send_item(REQ_AUDIO,  16'h8001, 1'b1);
        send_item(REQ_AUDIO,  16'hAAAA, 1'b1);
        send_item(REQ_AUDIO,  16'h5555, 1'b0);
        send_item(REQ_RECAL,  16'h0000, 1'b0);
        send_item(REQ_AUDIO,  16'h8000, 1'b0);
        send_item(REQ_UNUSED, 16'h0000, 1'b0);
        send_item(REQ_AUDIO,  16'h7FFF, 1'b0);

        run_utterance(SENS_RESET, 1'b0, 1'b1, 100, 1'b0);
        run_utterance(8'hFF, 1'b1, 1'b0, 100, 1'b0);
        run_utterance(8'h00, 1'b1, 1'b1, 300, 1'b1);
        run_utterance(8'($urandom_range(254, 1)), 1'b1, 1'b0, 300, 1'b1);
        run_utterance(8'($urandom_range(254, 1)), 1'b1, 1'b1, 20, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("energy_speech_endpoint_detector_test: done, clean");
        else
            $display("energy_speech_endpoint_detector_test: done, errors");
        $finish;
    end

    // Output side: random stalls, long ready stretches, and one long hold-off
    initial begin : playback_sink
        int unsigned run_len, stall;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held && tracker.results_seen >= 1500) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            if ($urandom_range(7, 0) == 0)
                run_len = $urandom_range(600, 100);
            else
                run_len = $urandom_range(8, 1);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall = idle_len();
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #200_000_000;
        $display("energy_speech_endpoint_detector_test: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/esed_pkg.sv
rtl/esed_front.sv
rtl/esed_ring.sv
rtl/esed_outq.sv
rtl/energy_speech_endpoint_detector.sv
tb/energy_speech_endpoint_detector_test.sv
